// ===== rtl/cosine_similarity_threshold_unit_macros.svh =====
// Assertion macros for the cosine similarity threshold unit.
// Expects signals named clk and rst_n in the scope of use.
`ifndef COSINE_SIMILARITY_THRESHOLD_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_THRESHOLD_UNIT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define CST_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the trigger
`define CST_ASSERT_IMPL(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

`endif

// ===== rtl/cst_pkg.sv =====
// Shared constants and types of the cosine similarity threshold unit.
// No dependencies; used by every module of the block.
package cst_pkg;

    localparam int MAX_LENGTH   = 4096;
    localparam int ELEMENT_BITS = 16;
    localparam int FIELD_BITS   = 16;

    localparam int PROD_W  = 2 * ELEMENT_BITS;
    localparam int LEN_BITS = $clog2(MAX_LENGTH);
    localparam int COUNT_W = $clog2(MAX_LENGTH + 1);
    localparam int DOT_W   = PROD_W + LEN_BITS;
    localparam int NORM_W  = PROD_W - 1 + LEN_BITS;

    // norm product, its square root
    localparam int SQ_W       = 2 * NORM_W;
    localparam int ROOT_W     = NORM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SREM_W     = ROOT_W + 3;

    // norm product is built from 16-bit slices of the second norm
    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = (NORM_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MUL_PAD   = MUL_STEPS * MUL_CHUNK;
    localparam int PP_W      = NORM_W + MUL_CHUNK;

    // quotient
    localparam int FRAC_BITS = 15;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DIV_STEPS = Q_W;
    localparam int DREM_W    = DOT_W + 1;

    localparam int STEP_W = $clog2(SQRT_STEPS + DIV_STEPS + MUL_STEPS);

    localparam int SIM_W = 16;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0] Q_MAX = Q_ONE - Q_W'(1);
    localparam logic signed [SIM_W-1:0] THRESHOLD_RESET = 16'sd32112;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_USER_W = 3;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_a;
        logic [NORM_W-1:0]       norm_b;
        logic                    overflow;
    } vec_sums_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_SQRT = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } back_state_t;

endpackage

// ===== rtl/cst_front.sv =====
// Front end: takes element pairs, multiplies, accumulates dot and norms.
// Pushes the finished sums of a vector into the queue. Uses cst_pkg.
module cst_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [2*cst_pkg::FIELD_BITS-1:0] s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic [cst_pkg::QCNT_W-1:0]       q_count,
    output logic                             q_push,
    output cst_pkg::vec_sums_t               q_push_data
);

    logic signed [cst_pkg::ELEMENT_BITS-1:0] elem_a;
    logic signed [cst_pkg::ELEMENT_BITS-1:0] elem_b;
    logic accept;
    logic take;

    logic [cst_pkg::COUNT_W-1:0] pair_count_reg, pair_count_next;
    logic                        overflow_seen_reg, overflow_seen_next;

    // product stage
    logic                              pv_reg, plast_reg, ptake_reg, povf_reg;
    logic signed [cst_pkg::PROD_W-1:0] pdot_reg, pa_reg, pb_reg;

    logic signed [cst_pkg::DOT_W-1:0] dot_sum_reg, dot_sum_next, dot_acc;
    logic [cst_pkg::NORM_W-1:0]       norm_a_reg, norm_a_next, norm_a_acc;
    logic [cst_pkg::NORM_W-1:0]       norm_b_reg, norm_b_next, norm_b_acc;
    logic                             in_flight;

    assign elem_a = s_axis_tdata[cst_pkg::ELEMENT_BITS-1:0];
    assign elem_b = s_axis_tdata[cst_pkg::FIELD_BITS +: cst_pkg::ELEMENT_BITS];

    // a vector end already in the product stage still has to land in the queue
    assign in_flight = pv_reg & plast_reg;
    assign s_axis_tready = ({1'b0, q_count} + (cst_pkg::QCNT_W + 1)'(in_flight))
                           < (cst_pkg::QCNT_W + 1)'(cst_pkg::QUEUE_DEPTH);
    assign accept = s_axis_tvalid & s_axis_tready;
    assign take   = pair_count_reg < cst_pkg::COUNT_W'(cst_pkg::MAX_LENGTH);

    always_comb
    begin
        pair_count_next    = pair_count_reg;
        overflow_seen_next = overflow_seen_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                pair_count_next    = '0;
                overflow_seen_next = 1'b0;
            end
            else if (take)
            begin
                pair_count_next = pair_count_reg + cst_pkg::COUNT_W'(1);
            end
            else
            begin
                overflow_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            pv_reg            <= 1'b0;
        end
        else
        begin
            pair_count_reg    <= pair_count_next;
            overflow_seen_reg <= overflow_seen_next;
            pv_reg            <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plast_reg <= s_axis_tlast;
            ptake_reg <= take;
            povf_reg  <= overflow_seen_reg | ~take;
            pdot_reg  <= cst_pkg::PROD_W'(elem_a) * cst_pkg::PROD_W'(elem_b);
            pa_reg    <= cst_pkg::PROD_W'(elem_a) * cst_pkg::PROD_W'(elem_a);
            pb_reg    <= cst_pkg::PROD_W'(elem_b) * cst_pkg::PROD_W'(elem_b);
        end
    end

    always_comb
    begin
        dot_acc    = dot_sum_reg;
        norm_a_acc = norm_a_reg;
        norm_b_acc = norm_b_reg;
        if (ptake_reg)
        begin
            dot_acc    = dot_sum_reg + cst_pkg::DOT_W'(pdot_reg);
            norm_a_acc = norm_a_reg + cst_pkg::NORM_W'(pa_reg[cst_pkg::PROD_W-2:0]);
            norm_b_acc = norm_b_reg + cst_pkg::NORM_W'(pb_reg[cst_pkg::PROD_W-2:0]);
        end

        dot_sum_next = dot_sum_reg;
        norm_a_next  = norm_a_reg;
        norm_b_next  = norm_b_reg;
        if (pv_reg)
        begin
            if (plast_reg)
            begin
                dot_sum_next = '0;
                norm_a_next  = '0;
                norm_b_next  = '0;
            end
            else
            begin
                dot_sum_next = dot_acc;
                norm_a_next  = norm_a_acc;
                norm_b_next  = norm_b_acc;
            end
        end
    end

    assign q_push               = pv_reg & plast_reg;
    assign q_push_data.dot      = dot_acc;
    assign q_push_data.norm_a   = norm_a_acc;
    assign q_push_data.norm_b   = norm_b_acc;
    assign q_push_data.overflow = povf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_sum_reg <= '0;
            norm_a_reg  <= '0;
            norm_b_reg  <= '0;
        end
        else
        begin
            dot_sum_reg <= dot_sum_next;
            norm_a_reg  <= norm_a_next;
            norm_b_reg  <= norm_b_next;
        end
    end

endmodule

// ===== rtl/cst_queue.sv =====
// Short queue of per-vector sums between front end and back end.
// Uses cst_pkg for depth and entry type.
module cst_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  cst_pkg::vec_sums_t         push_data,
    input  logic                       pop,
    output logic                       valid,
    output cst_pkg::vec_sums_t         pop_data,
    output logic [cst_pkg::QCNT_W-1:0] count
);

    cst_pkg::vec_sums_t entry_reg [cst_pkg::QUEUE_DEPTH];
    logic [cst_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cst_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cst_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_pop;

    assign valid    = count_reg != '0;
    assign count    = count_reg;
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_pop   = pop & valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == cst_pkg::QPTR_W'(cst_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + cst_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cst_pkg::QPTR_W'(cst_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + cst_pkg::QPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + cst_pkg::QCNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - cst_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/cst_back.sv =====
// Back end: norm product, integer square root and Q1.15 divide, one step
// per cycle, then the output register. Uses cst_pkg.
module cst_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  cst_pkg::vec_sums_t                     q_data,
    output logic                                   q_pop,
    input  logic signed [cst_pkg::SIM_W-1:0]       threshold,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [cst_pkg::SIM_W-1:0]              m_axis_tdata,
    output logic [cst_pkg::OUT_USER_W-1:0]         m_axis_tuser
);

    cst_pkg::back_state_t state_reg, state_next;
    logic [cst_pkg::STEP_W-1:0] step_reg, step_next;

    logic signed [cst_pkg::DOT_W-1:0] dot_reg, dot_next;
    logic [cst_pkg::NORM_W-1:0]  na_reg, na_next;
    logic [cst_pkg::MUL_PAD-1:0] nb_reg, nb_next;
    logic [cst_pkg::PP_W-1:0]    pp_reg, pp_next;
    logic [cst_pkg::SQ_W-1:0]    prod_reg, prod_next;
    logic [cst_pkg::SREM_W-1:0]  srem_reg, srem_next;
    logic [cst_pkg::ROOT_W-1:0]  root_reg, root_next;
    logic [cst_pkg::DREM_W-1:0]  drem_reg, drem_next;
    logic [cst_pkg::Q_W-1:0]     q_reg, q_next;
    logic ovf_reg, ovf_next, zero_reg, zero_next, neg_reg, neg_next;

    logic out_valid_reg, out_valid_next;
    logic [cst_pkg::SIM_W-1:0] out_sim_reg, out_sim_next;
    logic [cst_pkg::OUT_USER_W-1:0] out_user_reg, out_user_next;

    logic [cst_pkg::SREM_W-1:0] srem_try, srem_trial;
    logic [cst_pkg::DREM_W-1:0] drem_try;
    logic [cst_pkg::DOT_W-1:0]  dot_mag;
    logic [cst_pkg::Q_W-1:0]    q_clamp;
    logic signed [cst_pkg::SIM_W:0] sim_wide;
    logic signed [cst_pkg::SIM_W-1:0] sim;
    logic out_free;

    assign out_free = ~out_valid_reg | m_axis_tready;
    assign q_pop    = (state_reg == cst_pkg::ST_IDLE) & q_valid;

    // restoring square root: two radicand bits per step
    assign srem_try   = {srem_reg[cst_pkg::SREM_W-3:0], prod_reg[cst_pkg::SQ_W-1 -: 2]};
    assign srem_trial = cst_pkg::SREM_W'({root_reg, 2'b01});

    // first divide step compares without a shift
    assign drem_try = (step_reg == '0) ? drem_reg : (drem_reg << 1);

    assign dot_mag = dot_reg[cst_pkg::DOT_W-1] ? cst_pkg::DOT_W'(-dot_reg)
                                               : cst_pkg::DOT_W'(dot_reg);

    always_comb
    begin
        q_clamp = (q_reg > cst_pkg::Q_ONE) ? cst_pkg::Q_ONE : q_reg;
        if (neg_reg)
        begin
            sim_wide = -$signed({1'b0, q_clamp});
        end
        else
        begin
            sim_wide = $signed({1'b0, (q_clamp > cst_pkg::Q_MAX) ? cst_pkg::Q_MAX : q_clamp});
        end
        sim = sim_wide[cst_pkg::SIM_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        dot_next       = dot_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        pp_next        = pp_reg;
        prod_next      = prod_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        q_next         = q_reg;
        ovf_next       = ovf_reg;
        zero_next      = zero_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_sim_next   = out_sim_reg;
        out_user_next  = out_user_reg;

        case (state_reg)
            cst_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    dot_next  = q_data.dot;
                    na_next   = q_data.norm_a;
                    nb_next   = cst_pkg::MUL_PAD'(q_data.norm_b);
                    ovf_next  = q_data.overflow;
                    prod_next = '0;
                    step_next = '0;
                    if (q_data.norm_a == '0 || q_data.norm_b == '0)
                    begin
                        zero_next  = 1'b1;
                        neg_next   = 1'b0;
                        q_next     = '0;
                        state_next = cst_pkg::ST_DONE;
                    end
                    else
                    begin
                        zero_next  = 1'b0;
                        state_next = cst_pkg::ST_MUL;
                    end
                end
            end

            cst_pkg::ST_MUL:
            begin
                // top slice first: prod = prod * 2^16 + na * slice
                if (step_reg != '0)
                begin
                    prod_next = (prod_reg << cst_pkg::MUL_CHUNK) + cst_pkg::SQ_W'(pp_reg);
                end
                if (step_reg < cst_pkg::STEP_W'(cst_pkg::MUL_STEPS))
                begin
                    pp_next = cst_pkg::PP_W'(na_reg)
                              * cst_pkg::PP_W'(nb_reg[cst_pkg::MUL_PAD-1 -: cst_pkg::MUL_CHUNK]);
                    nb_next = nb_reg << cst_pkg::MUL_CHUNK;
                    step_next = step_reg + cst_pkg::STEP_W'(1);
                end
                else
                begin
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = cst_pkg::ST_SQRT;
                end
            end

            cst_pkg::ST_SQRT:
            begin
                prod_next = prod_reg << 2;
                if (srem_try >= srem_trial)
                begin
                    srem_next = srem_try - srem_trial;
                    root_next = {root_reg[cst_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_try;
                    root_next = {root_reg[cst_pkg::ROOT_W-2:0], 1'b0};
                end
                if (step_reg == cst_pkg::STEP_W'(cst_pkg::SQRT_STEPS - 1))
                begin
                    step_next  = '0;
                    q_next     = '0;
                    neg_next   = dot_reg[cst_pkg::DOT_W-1];
                    drem_next  = cst_pkg::DREM_W'(dot_mag);
                    state_next = cst_pkg::ST_DIV;
                end
                else
                begin
                    step_next = step_reg + cst_pkg::STEP_W'(1);
                end
            end

            cst_pkg::ST_DIV:
            begin
                if (drem_try >= cst_pkg::DREM_W'(root_reg))
                begin
                    drem_next = drem_try - cst_pkg::DREM_W'(root_reg);
                    q_next    = {q_reg[cst_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = drem_try;
                    q_next    = {q_reg[cst_pkg::Q_W-2:0], 1'b0};
                end
                if (step_reg == cst_pkg::STEP_W'(cst_pkg::DIV_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = cst_pkg::ST_DONE;
                end
                else
                begin
                    step_next = step_reg + cst_pkg::STEP_W'(1);
                end
            end

            cst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sim_next   = sim;
                    // tuser: length_overflow, zero_norm, converged
                    out_user_next  = {ovf_reg, zero_reg, sim > threshold};
                    state_next     = cst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cst_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg      <= dot_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        pp_reg       <= pp_next;
        prod_reg     <= prod_next;
        srem_reg     <= srem_next;
        root_reg     <= root_next;
        drem_reg     <= drem_next;
        q_reg        <= q_next;
        ovf_reg      <= ovf_next;
        zero_reg     <= zero_next;
        neg_reg      <= neg_next;
        out_sim_reg  <= out_sim_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sim_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== rtl/cosine_similarity_threshold_unit.sv =====
// Cosine similarity threshold unit: top level with the threshold register.
// Depends on cst_pkg, cst_front, cst_queue, cst_back and the macros header.
//
// Input stream: one element pair per item, element_a in tdata[15:0] and
// element_b in tdata[31:16]; tlast marks the final pair of a vector.
// Pairs are taken at one per cycle while tready is high. Dot product and both
// squared norms are summed exactly; pairs beyond 4096 per vector are dropped
// and flagged. Output stream: one item per vector, similarity (Q1.15) in
// tdata[15:0], tuser = {length_overflow, zero_norm, converged}.
// From the last pair to its result, the work passes the front-end product
// register and the queue, a load, the 43x43 norm product in 16-bit slices,
// 43 square root steps, 16 divide steps and the output register. The back
// end handles one vector at a time; a two-entry queue lets the front end keep
// taking pairs while the back end works. A stalled output holds its item and
// the back end waits before loading the next result; the queue then fills and
// tready drops. Reset clears all sums, counts and queued work and sets
// threshold to 32112. Threshold is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, since the block does not
// enforce this.
`include "cosine_similarity_threshold_unit_macros.svh"

module cosine_similarity_threshold_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cst_pkg::SIM_W-1:0]           cfg_wdata,   // threshold
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [2*cst_pkg::FIELD_BITS-1:0]    s_axis_tdata,  // element_a, element_b
    input  logic                                s_axis_tlast,  // last_element
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cst_pkg::SIM_W-1:0]           m_axis_tdata,  // similarity
    output logic [cst_pkg::OUT_USER_W-1:0]      m_axis_tuser   // converged, zero_norm,
                                                               // length_overflow
);

    logic signed [cst_pkg::SIM_W-1:0] threshold_reg, threshold_next;

    logic                       q_push, q_pop, q_valid;
    cst_pkg::vec_sums_t         q_push_data, q_pop_data;
    logic [cst_pkg::QCNT_W-1:0] q_count;

    assign threshold_next = cfg_we ? $signed(cfg_wdata) : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= cst_pkg::THRESHOLD_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    cst_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    cst_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_pop_data),
        .count     (q_count)
    );

    cst_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .threshold     (threshold_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // the front end must never finish a vector into a full queue
    `CST_ASSERT_IMPL(a_push_room, q_push, q_count < cst_pkg::QCNT_W'(cst_pkg::QUEUE_DEPTH), "vector sums pushed into a full queue")
    // back end takes work only when some is queued
    `CST_ASSERT_IMPL(a_pop_valid, q_pop, q_valid, "back end popped an empty queue")
    // a zero norm result carries zero similarity
    `CST_ASSERT_IMPL(a_zero_sim, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == '0, "zero norm item with nonzero similarity")
    `CST_ASSERT(a_count_range, q_count <= cst_pkg::QCNT_W'(cst_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== test/cst_similarity_scoreboard.sv =====
// Scoreboard for the cosine similarity threshold unit: watches the config port
// and both streams, predicts every vector result and compares it field by field.
// Depends on cst_pkg for port widths and the threshold reset value.
module cst_similarity_scoreboard
    import cst_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [SIM_W-1:0]             cfg_wdata,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [2*FIELD_BITS-1:0]      s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [SIM_W-1:0]             m_axis_tdata,
    input  logic [OUT_USER_W-1:0]        m_axis_tuser,
    output int                           errors,
    output int                           outstanding,
    output int                           results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        logic                    converged;
        logic                    zero_norm;
        logic                    length_overflow;
    } cos_result_t;

    cos_result_t expected_q[$];

    // running sums of the vector pair in flight
    longint      dot_acc;
    logic [63:0] norm_a_acc;
    logic [63:0] norm_b_acc;
    int          pairs_taken;
    logic        overflow_flag;
    int          threshold_q;

    function automatic cos_result_t vector_result();
        cos_result_t  r;
        logic [127:0] prod;
        logic [127:0] root;
        logic [127:0] trial;
        logic [127:0] mag;
        logic [127:0] quo;
        int           q_int;
        int           sim_int;
        int           bit_pos;
        r = '0;
        if (norm_a_acc == 0 || norm_b_acc == 0)
        begin
            r.zero_norm = 1'b1;
            sim_int = 0;
        end
        else
        begin
            prod = {64'd0, norm_a_acc} * {64'd0, norm_b_acc};
            root = '0;
            for (bit_pos = 62; bit_pos >= 0; bit_pos--)
            begin
                trial = root | (128'd1 << bit_pos);
                if (trial * trial <= prod)
                    root = trial;
            end
            // |dot| never exceeds the root, so the quotient tops out at 1.0
            mag = (dot_acc < 0) ? 128'(-dot_acc) : 128'(dot_acc);
            quo = (mag << 15) / root;
            if (quo > 128'd32768)
                quo = 128'd32768;
            q_int = int'(quo[31:0]);
            sim_int = (dot_acc < 0) ? -q_int : ((q_int > 32767) ? 32767 : q_int);
        end
        r.similarity      = 16'(sim_int);
        r.converged       = (sim_int > threshold_q);
        r.length_overflow = overflow_flag;
        return r;
    endfunction

    function automatic int field_differs(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cos_result_t             got;
        cos_result_t             want;
        logic signed [FIELD_BITS-1:0] ea;
        logic signed [FIELD_BITS-1:0] eb;
        int                      bad;
        if (!rst_n)
        begin
            expected_q.delete();
            dot_acc         = 0;
            norm_a_acc      = '0;
            norm_b_acc      = '0;
            pairs_taken     = 0;
            overflow_flag   = 1'b0;
            threshold_q     = int'(THRESHOLD_RESET);
            errors          <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_we)
                threshold_q = int'($signed(cfg_wdata));

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.similarity      = m_axis_tdata;
                got.converged       = m_axis_tuser[0];
                got.zero_norm       = m_axis_tuser[1];
                got.length_overflow = m_axis_tuser[2];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual similarity %0d",
                             $time, $signed(got.similarity));
                    bad++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad += field_differs("similarity", int'(want.similarity),
                                         int'(got.similarity));
                    bad += field_differs("converged", want.converged, got.converged);
                    bad += field_differs("zero_norm", want.zero_norm, got.zero_norm);
                    bad += field_differs("length_overflow", want.length_overflow,
                                         got.length_overflow);
                end
                results_checked <= results_checked + 1;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                ea = s_axis_tdata[FIELD_BITS-1:0];
                eb = s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS];
                // pairs past the length limit are dropped but remembered
                if (pairs_taken < MAX_LENGTH)
                begin
                    dot_acc    += longint'(ea) * longint'(eb);
                    norm_a_acc += 64'(longint'(ea) * longint'(ea));
                    norm_b_acc += 64'(longint'(eb) * longint'(eb));
                    pairs_taken++;
                end
                else
                    overflow_flag = 1'b1;
                if (s_axis_tlast)
                begin
                    expected_q    = {expected_q, vector_result()};
                    dot_acc       = 0;
                    norm_a_acc    = '0;
                    norm_b_acc    = '0;
                    pairs_taken   = 0;
                    overflow_flag = 1'b0;
                end
            end

            errors      <= errors + bad;
            outstanding <= expected_q.size();
        end
    end

endmodule

// ===== test/tb_cosine_similarity_threshold_unit.sv =====
// Testbench top for the cosine similarity threshold unit: drives vector pairs,
// thresholds and output back-pressure; cst_similarity_scoreboard does the checking.
// Depends on cst_pkg, the unit RTL and cst_similarity_scoreboard.
module tb_cosine_similarity_threshold_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;

    typedef enum {
        VK_RANDOM,
        VK_SMALL,
        VK_SAME,
        VK_OPPOSED,
        VK_SCALED,
        VK_ZERO_FIRST,
        VK_ZERO_SECOND
    } vec_kind_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [SIM_W-1:0]          cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [2*FIELD_BITS-1:0]   s_axis_tdata;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [SIM_W-1:0]          m_axis_tdata;
    logic [OUT_USER_W-1:0]     m_axis_tuser;

    int errors;
    int outstanding;
    int results_checked;

    int gap_pct;
    int stall_pct;
    int cycle_count;
    int pairs_sent;
    int vectors_sent;

    cosine_similarity_threshold_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cst_similarity_scoreboard u_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("** cosine_similarity_threshold_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic send_pair(input logic [FIELD_BITS-1:0] a, input logic [FIELD_BITS-1:0] b,
                             input logic last);
        // each cycle the sender idles with probability gap_pct
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pairs_sent++;
        if (last)
            vectors_sent++;
    endtask

    task automatic send_vector(input int len, input vec_kind_t kind);
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        int                    shift;
        shift = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (kind)
                VK_SMALL:
                begin
                    a = 16'(int'($urandom_range(0, 14)) - 7);
                    b = 16'(int'($urandom_range(0, 14)) - 7);
                end
                VK_SAME:        b = a;
                VK_OPPOSED:     b = -a;
                VK_SCALED:      b = 16'($signed(a) >>> shift);
                VK_ZERO_FIRST:  a = '0;
                VK_ZERO_SECOND: b = '0;
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    // hold off until every result is back, then let the back end go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [SIM_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int gap, input int stall, input logic [SIM_W-1:0] thr,
                             input int target);
        int start;
        int len;
        write_threshold(thr);
        gap_pct   = gap;
        stall_pct = stall;
        start     = pairs_sent;
        while (pairs_sent - start < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
            send_vector(len, vec_kind_t'($urandom_range(0, 6)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        gap_pct       = 0;
        stall_pct     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // threshold still at its reset value
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);        // +1.0 clamps to 32767
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);        // exactly -1.0
        send_pair(16'h0000, 16'h0005, 1'b1);        // zero norm
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0001, 16'h0001, 1'b0);        // orthogonal pair
        send_pair(16'h0001, 16'hFFFF, 1'b1);
        send_pair(16'h0003, 16'hFFFC, 1'b0);
        send_pair(16'h0001, 16'h0002, 1'b0);
        send_pair(16'hFFFB, 16'h0006, 1'b1);

        // most negative threshold: a zero-norm result counts as converged
        write_threshold(16'h8000);
        send_pair(16'h0000, 16'h0007, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h0064, 16'h005A, 1'b0);
        send_pair(16'hFFFD, 16'h0004, 1'b1);

        write_threshold(16'h7FFF);
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);
        send_pair(16'h0005, 16'h0000, 1'b1);

        write_threshold(16'h0000);
        send_pair(16'h0002, 16'h0003, 1'b0);
        send_pair(16'h0003, 16'hFFFE, 1'b1);
        send_pair(16'hFFFF, 16'hFFFF, 1'b1);

        // full-length vector at the largest magnitudes fills every sum to the top;
        // one pair too many follows, which would pull the result below +1.0
        // if it were summed: it is dropped and flagged
        for (int i = 0; i < MAX_LENGTH; i++)
            send_pair(16'h8000, 16'h8000, 1'b0);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        send_pair(16'h000A, 16'h0014, 1'b1);        // flag must be clear again

        run_phase(0, 0, 16'($urandom), 125);
        run_phase(53, 0, 16'hC000, 125);
        run_phase(0, 53, 16'($urandom_range(24000, 32767)), 125);
        run_phase(21, 21, 16'($urandom), 125);
        gap_pct   = 0;
        stall_pct = 0;
        settle();

        $display("Sent %0d element pairs in %0d vectors; %0d results checked.",
                 pairs_sent, vectors_sent, results_checked);
        $display("Covered clamping at +/-1, zero norms, length overflow and four flow mixes.");
        if (errors == 0 && outstanding == 0)
            $display("** cosine_similarity_threshold_unit: PASSED **");
        else
            $display("** cosine_similarity_threshold_unit: FAILED **");
        $finish;
    end

endmodule
